// ----- rtl/cdg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdg_pkg
// Shared constants and types of the central-difference gradient block.
// ----------------------------------------------------------------------------
package cdg_pkg;

    localparam int PIXEL_BITS_DEF  = 16;
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int ROW_LIMIT       = 4096;
    localparam int ROW_BITS        = 12;
    localparam int COL_REG_BITS    = 11;
    localparam int ROW_REG_BITS    = 13;
    localparam int CFG_DATA_BITS   = 13;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int COLS_RESET      = 64;
    localparam int ROWS_RESET      = 64;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_COLUMNS = 1'b0,
        REG_IMAGE_ROWS    = 1'b1
    } cdg_reg_t;

    // Position flags of the word held in the compute stage.
    typedef struct packed {
        logic first_col;
        logic second_col;
        logic last_col;
        logic row_one;
        logic last_row;
    } cdg_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/cdg_line_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdg_line_buf
// One-row line buffer: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module cdg_line_buf #(
    parameter int WIDTH = cdg_pkg::PIXEL_BITS_DEF,
    parameter int DEPTH = cdg_pkg::MAX_COLUMNS_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr_a,
    input  wire logic [AW-1:0]    rd_addr_b,
    output logic      [WIDTH-1:0] rd_data_a,
    output logic      [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/cdg_grad.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdg_grad
// Gradient arithmetic for the up to three result words of one pixel.
// ----------------------------------------------------------------------------
module cdg_grad #(
    parameter int PIXEL_BITS = cdg_pkg::PIXEL_BITS_DEF,
    localparam int GB        = PIXEL_BITS + 2
) (
    input  wire cdg_pkg::cdg_ctl_t        ctl,
    input  wire logic signed [PIXEL_BITS-1:0] cur,
    input  wire logic signed [PIXEL_BITS-1:0] up_c,
    input  wire logic signed [PIXEL_BITS-1:0] up_n,
    input  wire logic signed [PIXEL_BITS-1:0] up_l,
    input  wire logic signed [PIXEL_BITS-1:0] up2_c,
    input  wire logic signed [PIXEL_BITS-1:0] left,
    input  wire logic signed [PIXEL_BITS-1:0] left2,
    output logic signed [GB-1:0]          gx [3],
    output logic signed [GB-1:0]          gy [3]
);

    logic signed [GB-1:0] cur_x, up_c_x, up_n_x, up_l_x, up2_c_x, left_x, left2_x;
    logic signed [GB-1:0] d_upn_upc, d_upc_upl, d_upn_upl;
    logic signed [GB-1:0] d_cur_upc, d_cur_up2c, d_cur_left, d_cur_left2, d_left_upl;

    assign cur_x   = GB'(cur);
    assign up_c_x  = GB'(up_c);
    assign up_n_x  = GB'(up_n);
    assign up_l_x  = GB'(up_l);
    assign up2_c_x = GB'(up2_c);
    assign left_x  = GB'(left);
    assign left2_x = GB'(left2);

    assign d_upn_upc   = up_n_x - up_c_x;
    assign d_upc_upl   = up_c_x - up_l_x;
    assign d_upn_upl   = up_n_x - up_l_x;
    assign d_cur_upc   = cur_x - up_c_x;
    assign d_cur_up2c  = cur_x - up2_c_x;
    assign d_cur_left  = cur_x - left_x;
    assign d_cur_left2 = cur_x - left2_x;
    assign d_left_upl  = left_x - up_l_x;

    always_comb begin
        if (ctl.first_col) begin
            gx[0] = d_upn_upc <<< 1;
        end else if (ctl.last_col) begin
            gx[0] = d_upc_upl <<< 1;
        end else begin
            gx[0] = d_upn_upl;
        end
        gy[0] = ctl.row_one ? (d_cur_upc <<< 1) : d_cur_up2c;

        gx[1] = ctl.second_col ? (d_cur_left <<< 1) : d_cur_left2;
        gy[1] = d_left_upl <<< 1;

        gx[2] = d_cur_left <<< 1;
        gy[2] = d_cur_upc <<< 1;
    end

endmodule
`default_nettype wire

// ----- rtl/image_central_difference_gradient_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_central_difference_gradient_top
// Pixel (r, c) enters the compute stage, whose word for (r-1, c) is registered
//   at the output; row 0 gives no words. Unstalled: one pixel per cycle,
//   set by the line-buffer read at accept and one result register; a last-row
//   pixel gives up to three words, one per cycle. Reset clears counters,
//   left-pixel history and configuration (64 x 64), not the line buffers.
// ----------------------------------------------------------------------------
module image_central_difference_gradient_top #(
    parameter int MAX_COLUMNS = cdg_pkg::MAX_COLUMNS_DEF,
    parameter int PIXEL_BITS  = cdg_pkg::PIXEL_BITS_DEF,
    localparam int CW         = $clog2(MAX_COLUMNS),
    localparam int GB         = PIXEL_BITS + 2,
    localparam int RB         = cdg_pkg::ROW_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [cdg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [cdg_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [PIXEL_BITS-1:0]         s_pixel_value,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [RB-1:0]                             m_out_row,
    output logic [CW-1:0]                             m_out_column,
    output logic signed [GB-1:0]                      m_x_gradient,
    output logic signed [GB-1:0]                      m_y_gradient,
    output logic                                      m_frame_last
);

    localparam int RRB = cdg_pkg::ROW_REG_BITS;
    localparam int COLS_CLAMP_RST =
        (cdg_pkg::COLS_RESET > MAX_COLUMNS) ? MAX_COLUMNS : cdg_pkg::COLS_RESET;

    // configuration
    logic [CW-1:0]  cols_last_reg, cols_last_next;
    logic [RB-1:0]  rows_last_reg, rows_last_next;
    logic [RRB-1:0] cols_raw, rows_raw;

    // position counters
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [RB-1:0] row_cnt_reg, row_cnt_next;
    logic [CW-1:0] c_eff;
    logic [RB-1:0] r_eff;

    // compute stage
    logic                      b_valid_reg;
    logic [2:0]                pend_reg, pend_next, pend_new, pend_clr;
    cdg_pkg::cdg_ctl_t         b_ctl_reg, ctl_new;
    logic [CW-1:0]             b_col_reg;
    logic [RB-1:0]             b_row_reg;
    logic signed [PIXEL_BITS-1:0] b_pix_reg;
    logic signed [PIXEL_BITS-1:0] left_reg, left2_reg;
    logic                      hit_pa_reg, hit_pb_reg, hit_oa_reg, hit_ob_reg;
    logic signed [PIXEL_BITS-1:0] byp_p_reg, byp_o_reg;

    // line buffer ports
    logic [CW-1:0]             rd_pa, rd_pb, rd_oa, rd_ob;
    logic [PIXEL_BITS-1:0]     rdp_a, rdp_b, rdo_a, rdo_b;
    logic signed [PIXEL_BITS-1:0] up_c, up_n, up_l, up2_c;

    // handshakes
    logic s_accept, out_load, b_done, wr_en;
    logic [1:0] sel;
    logic signed [GB-1:0] gx [3];
    logic signed [GB-1:0] gy [3];

    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;

    // clamp register values on write
    assign cols_raw = RRB'(cfg_data[cdg_pkg::COL_REG_BITS-1:0]);
    assign rows_raw = cfg_data[RRB-1:0];

    always_comb begin
        if (cols_raw < RRB'(2)) begin
            cols_last_next = CW'(1);
        end else if (cols_raw > RRB'(MAX_COLUMNS)) begin
            cols_last_next = CW'(MAX_COLUMNS - 1);
        end else begin
            cols_last_next = CW'(cols_raw - RRB'(1));
        end
        if (rows_raw < RRB'(2)) begin
            rows_last_next = RB'(1);
        end else if (rows_raw > RRB'(cdg_pkg::ROW_LIMIT)) begin
            rows_last_next = RB'(cdg_pkg::ROW_LIMIT - 1);
        end else begin
            rows_last_next = RB'(rows_raw - RRB'(1));
        end
    end

    // position of the incoming word
    assign c_eff = (col_cnt_reg > cols_last_reg) ? cols_last_reg : col_cnt_reg;
    assign r_eff = (row_cnt_reg > rows_last_reg) ? rows_last_reg : row_cnt_reg;

    always_comb begin
        ctl_new.first_col  = (c_eff == '0);
        ctl_new.second_col = (c_eff == CW'(1));
        ctl_new.last_col   = (c_eff == cols_last_reg);
        ctl_new.row_one    = (r_eff == RB'(1));
        ctl_new.last_row   = (r_eff == rows_last_reg);
        pend_new[0] = (r_eff != '0);
        pend_new[1] = pend_new[0] && ctl_new.last_row && !ctl_new.first_col;
        pend_new[2] = pend_new[0] && ctl_new.last_row && ctl_new.last_col;
        if (ctl_new.last_col) begin
            col_cnt_next = '0;
            row_cnt_next = ctl_new.last_row ? '0 : r_eff + RB'(1);
        end else begin
            col_cnt_next = c_eff + CW'(1);
            row_cnt_next = r_eff;
        end
    end

    assign rd_pa = c_eff;
    assign rd_pb = ctl_new.last_col ? c_eff : c_eff + CW'(1);
    assign rd_oa = ctl_new.first_col ? c_eff : c_eff - CW'(1);
    assign rd_ob = c_eff;

    // line buffers: previous row and the row above it
    cdg_line_buf #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_prev_buf (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (b_col_reg),
        .wr_data   (b_pix_reg),
        .rd_en     (s_accept),
        .rd_addr_a (rd_pa),
        .rd_addr_b (rd_pb),
        .rd_data_a (rdp_a),
        .rd_data_b (rdp_b)
    );

    cdg_line_buf #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_older_buf (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (b_col_reg),
        .wr_data   (up_c),
        .rd_en     (s_accept),
        .rd_addr_a (rd_oa),
        .rd_addr_b (rd_ob),
        .rd_data_a (rdo_a),
        .rd_data_b (rdo_b)
    );

    // forward a write made at the same edge as the read
    assign up_c  = hit_pa_reg ? byp_p_reg : $signed(rdp_a);
    assign up_n  = hit_pb_reg ? byp_p_reg : $signed(rdp_b);
    assign up_l  = hit_oa_reg ? byp_o_reg : $signed(rdo_a);
    assign up2_c = hit_ob_reg ? byp_o_reg : $signed(rdo_b);

    cdg_grad #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_grad (
        .ctl   (b_ctl_reg),
        .cur   (b_pix_reg),
        .up_c  (up_c),
        .up_n  (up_n),
        .up_l  (up_l),
        .up2_c (up2_c),
        .left  (left_reg),
        .left2 (left2_reg),
        .gx    (gx),
        .gy    (gy)
    );

    // emit pending words lowest first
    always_comb begin
        if (pend_reg[0]) begin
            sel      = 2'd0;
            pend_clr = {pend_reg[2:1], 1'b0};
        end else if (pend_reg[1]) begin
            sel      = 2'd1;
            pend_clr = {pend_reg[2], 2'b00};
        end else begin
            sel      = 2'd2;
            pend_clr = 3'b000;
        end
    end

    assign out_load  = b_valid_reg && (pend_reg != '0) && (!m_valid || m_ready);
    assign b_done    = b_valid_reg && ((pend_reg == '0) || (out_load && pend_clr == '0));
    assign wr_en     = b_done;
    assign s_ready   = !b_valid_reg || b_done;
    assign pend_next = s_accept ? pend_new : (out_load ? pend_clr : pend_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_last_reg <= CW'(COLS_CLAMP_RST - 1);
            rows_last_reg <= RB'(cdg_pkg::ROWS_RESET - 1);
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            b_valid_reg   <= 1'b0;
            left_reg      <= '0;
            left2_reg     <= '0;
            m_valid       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cdg_pkg::cdg_reg_t'(cfg_index))
                    cdg_pkg::REG_IMAGE_COLUMNS: cols_last_reg <= cols_last_next;
                    cdg_pkg::REG_IMAGE_ROWS:    rows_last_reg <= rows_last_next;
                    default: ;
                endcase
            end
            if (s_accept) begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
                b_valid_reg <= 1'b1;
            end else if (b_done) begin
                b_valid_reg <= 1'b0;
            end
            if (b_done) begin
                left2_reg <= left_reg;
                left_reg  <= b_pix_reg;
            end
            if (out_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        if (s_accept) begin
            b_ctl_reg  <= ctl_new;
            b_col_reg  <= c_eff;
            b_row_reg  <= r_eff;
            b_pix_reg  <= s_pixel_value;
            hit_pa_reg <= wr_en && (b_col_reg == rd_pa);
            hit_pb_reg <= wr_en && (b_col_reg == rd_pb);
            hit_oa_reg <= wr_en && (b_col_reg == rd_oa);
            hit_ob_reg <= wr_en && (b_col_reg == rd_ob);
            byp_p_reg  <= b_pix_reg;
            byp_o_reg  <= up_c;
        end
        if (out_load) begin
            m_x_gradient <= gx[sel];
            m_y_gradient <= gy[sel];
            m_frame_last <= (sel == 2'd2);
            case (sel)
                2'd0: begin
                    m_out_row    <= b_row_reg - RB'(1);
                    m_out_column <= b_col_reg;
                end
                2'd1: begin
                    m_out_row    <= b_row_reg;
                    m_out_column <= b_col_reg - CW'(1);
                end
                default: begin
                    m_out_row    <= b_row_reg;
                    m_out_column <= b_col_reg;
                end
            endcase
        end
    end

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> b_valid_reg)
        else $error("accepted word did not enter compute stage");

    a_stall_holds_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && (pend_reg != '0) && m_valid && !m_ready |=> $stable(pend_reg))
        else $error("pending words changed under output stall");

    a_left_word_not_first_col: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && pend_reg[1] |-> !b_ctl_reg.first_col && b_ctl_reg.last_row)
        else $error("left-neighbor word pending outside last row");

    a_final_word_position: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && pend_reg[2] |-> b_ctl_reg.last_col && b_ctl_reg.last_row)
        else $error("final word pending away from frame corner");

endmodule
`default_nettype wire

// ----- tb/sv/cdg_gradient_checker_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdg_gradient_checker_pkg
// Predicts the x/y gradient words of the central-difference block from the
// accepted pixel stream and register writes, and checks each result word
// against the oldest prediction.
// ----------------------------------------------------------------------------
package cdg_gradient_checker_pkg;

    import cdg_pkg::*;

    typedef struct {
        logic [ROW_BITS-1:0] row;
        logic [9:0]          column;
        logic signed [17:0]  x_grad;
        logic signed [17:0]  y_grad;
        logic                last;
    } gradient_word_t;

    class cdg_gradient_checker;
        int prev_line [MAX_COLUMNS_DEF];
        int older_line [MAX_COLUMNS_DEF];
        int row_pos;
        int col_pos;
        int left_px;
        int left2_px;
        int columns_reg;
        int rows_reg;
        gradient_word_t expected_words [$];
        int pixels_seen;
        int words_checked;
        int failures;

        function new();
            foreach (prev_line[i]) begin
                prev_line[i] = 0;
                older_line[i] = 0;
            end
            row_pos = 0;
            col_pos = 0;
            left_px = 0;
            left2_px = 0;
            columns_reg = COLS_RESET;
            rows_reg = ROWS_RESET;
            pixels_seen = 0;
            words_checked = 0;
            failures = 0;
        endfunction

        function void set_register(cdg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_IMAGE_COLUMNS: columns_reg = int'(data[COL_REG_BITS-1:0]);
                REG_IMAGE_ROWS: rows_reg = int'(data[ROW_REG_BITS-1:0]);
                default: ;
            endcase
        endfunction

        function void expect_word(int r, int c, int gx, int gy, bit last);
            gradient_word_t w;
            w.row = r[ROW_BITS-1:0];
            w.column = c[9:0];
            w.x_grad = gx[17:0];
            w.y_grad = gy[17:0];
            w.last = last;
            expected_words.push_back(w);
        endfunction

        function void note_pixel(logic signed [15:0] px);
            int cols;
            int rows;
            int c;
            int r;
            int cur;
            int gx;
            int gy;
            cols = columns_reg;
            rows = rows_reg;
            if (cols < 2) cols = 2;
            if (cols > MAX_COLUMNS_DEF) cols = MAX_COLUMNS_DEF;
            if (rows < 2) rows = 2;
            if (rows > ROW_LIMIT) rows = ROW_LIMIT;
            c = (col_pos > cols - 1) ? cols - 1 : col_pos;
            r = (row_pos > rows - 1) ? rows - 1 : row_pos;
            cur = px;
            pixels_seen++;

            if (r >= 1) begin
                if (c == 0) begin
                    gx = 2 * (prev_line[1] - prev_line[0]);
                end else if (c == cols - 1) begin
                    gx = 2 * (prev_line[c] - older_line[c - 1]);
                end else begin
                    gx = prev_line[c + 1] - older_line[c - 1];
                end
                if (r == 1) begin
                    gy = 2 * (cur - prev_line[c]);
                end else begin
                    gy = cur - older_line[c];
                end
                expect_word(r - 1, c, gx, gy, 1'b0);

                if (r == rows - 1) begin
                    if (c >= 1) begin
                        gx = (c == 1) ? 2 * (cur - left_px) : cur - left2_px;
                        gy = 2 * (left_px - older_line[c - 1]);
                        expect_word(r, c - 1, gx, gy, 1'b0);
                    end
                    if (c == cols - 1) begin
                        expect_word(r, c, 2 * (cur - left_px), 2 * (cur - prev_line[c]), 1'b1);
                    end
                end
            end

            older_line[c] = prev_line[c];
            prev_line[c] = cur;
            left2_px = left_px;
            left_px = cur;
            if (c == cols - 1) begin
                col_pos = 0;
                row_pos = (r == rows - 1) ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        function void check_word(logic [ROW_BITS-1:0] row, logic [9:0] column,
                                 logic signed [17:0] xg, logic signed [17:0] yg,
                                 logic last);
            gradient_word_t want;
            if (expected_words.size() == 0) begin
                $error("unexpected word: row %0d column %0d", row, column);
                failures++;
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (row !== want.row) begin
                $error("out_row: expected %0d, got %0d", want.row, row);
                failures++;
            end
            if (column !== want.column) begin
                $error("out_column: expected %0d, got %0d", want.column, column);
                failures++;
            end
            if (xg !== want.x_grad) begin
                $error("x_gradient: expected %0d, got %0d", want.x_grad, xg);
                failures++;
            end
            if (yg !== want.y_grad) begin
                $error("y_gradient: expected %0d, got %0d", want.y_grad, yg);
                failures++;
            end
            if (last !== want.last) begin
                $error("frame_last: expected %0d, got %0d", want.last, last);
                failures++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

endpackage

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the central-difference gradient block: directed frames with
// extreme pixels, clamped geometry and a mid-frame resize, then random frames
// under three idling mixes and a receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

    import cdg_pkg::*;
    import cdg_gradient_checker_pkg::*;

    localparam int STALL_LIMIT   = 3000;
    localparam int RECEIVER_HOLD = 400;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [15:0]         s_pixel_value = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [ROW_BITS-1:0]        m_out_row;
    logic [9:0]                 m_out_column;
    logic signed [17:0]         m_x_gradient;
    logic signed [17:0]         m_y_gradient;
    logic                       m_frame_last;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int frames_sent = 0;
    int frame_cols = 2;
    int frame_rows = 2;

    cdg_gradient_checker gradient_check = new();

    image_central_difference_gradient_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_row     (m_out_row),
        .m_out_column  (m_out_column),
        .m_x_gradient  (m_x_gradient),
        .m_y_gradient  (m_y_gradient),
        .m_frame_last  (m_frame_last)
    );

    always #6 aclk = ~aclk;

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                gradient_check.set_register(cdg_reg_t'(cfg_index), cfg_data);
            end
            if (s_valid && s_ready) begin
                gradient_check.note_pixel(s_pixel_value);
            end
            if (m_valid && m_ready) begin
                gradient_check.check_word(m_out_row, m_out_column, m_x_gradient,
                                          m_y_gradient, m_frame_last);
            end
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("image_central_difference_gradient_top regression: fail");
                $finish;
            end
        end
    end

    function automatic int random_pixel();
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // enter and leave at a falling edge; valid stays high after acceptance
    task automatic send_pixel(int value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel_value <= value[15:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_frame(int count);
        repeat (count) send_pixel(random_pixel());
        frames_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (gradient_check.pending() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic program_register(cdg_reg_t idx, int data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data[CFG_DATA_BITS-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_geometry(int col_data, int row_data);
        drain();
        program_register(REG_IMAGE_COLUMNS, col_data);
        program_register(REG_IMAGE_ROWS, row_data);
        cfg_valid <= 1'b0;
        frame_cols = clamp(col_data & 'h7FF, 2, MAX_COLUMNS_DEF);
        frame_rows = clamp(row_data & 'h1FFF, 2, ROW_LIMIT);
    endtask

    task automatic run_phase(int sender_pct, int receiver_pct, int target, bit with_hold);
        int sent;
        int cd;
        int rd;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        sent = 0;
        while (sent < target) begin
            if (sent == 0 || $urandom_range(0, 2) == 0) begin
                cd = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
                rd = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
                set_geometry(cd, rd);
                if (sent == 0 && with_hold) begin
                    hold_left = RECEIVER_HOLD;
                end
            end
            send_frame(frame_cols * frame_rows);
            sent += frame_cols * frame_rows;
        end
    endtask

    initial begin
        int extremes [6] = '{32767, -32768, -32768, 32767, 32767, -32768};
        int corners [4] = '{-1, 0, 0, -1};

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 26;
        recv_idle_pct = 81;
        set_geometry(2, 3);
        foreach (extremes[i]) send_pixel(extremes[i]);
        frames_sent++;

        set_geometry(0, 1);
        foreach (corners[i]) send_pixel(corners[i]);
        frames_sent++;

        // resize mid-frame: both counters land beyond the new last index
        set_geometry(4, 5);
        repeat (11) send_pixel(random_pixel());
        set_geometry(2, 2);
        send_pixel(random_pixel());
        frames_sent++;

        run_phase(26, 81, 70, 1'b0);
        run_phase(81, 26, 70, 1'b0);
        run_phase(0, 0, 70, 1'b1);

        drain();
        repeat (10) @(negedge aclk);

        $display("summary: %0d pixels in %0d frames, %0d gradient words checked",
                 gradient_check.pixels_seen, frames_sent, gradient_check.words_checked);
        $display("summary: clamped and mid-frame geometry, %0d-cycle receiver hold-off",
                 RECEIVER_HOLD);
        if (gradient_check.failures == 0 && gradient_check.pending() == 0) begin
            $display("image_central_difference_gradient_top regression: pass");
        end else begin
            $display("image_central_difference_gradient_top regression: fail");
        end
        $finish;
    end

endmodule
